/* design/cau_pkg.sv */
// Shared constants, codes and pipeline types for the complex arithmetic unit.
// No dependencies; used by cau_div_pipe and complex_arithmetic_unit.
`default_nettype none
package cau_pkg;

    // Operand format: signed fixed point, DW bits with FB fractional bits.
    localparam int DW = 16;
    localparam int FB = 8;
    localparam int AW = 3;

    localparam int PW = 2 * DW;      // full product width
    localparam int SW = PW + 1;      // sum of two products, signed
    localparam int MW = SW;          // magnitude width
    localparam int QW = DW + 1;      // quotient bits kept before clamping
    localparam int RW = PW + 1;      // divider remainder width
    localparam int QB = $clog2(QW);

    localparam int DIV_STAGES = (QW + 1) / 2;

    localparam int S_TDATA_W = ((AW + 4 * DW + 7) / 8) * 8;
    localparam int M_TDATA_W = ((2 * DW + 2 + 7) / 8) * 8;

    localparam logic [AW-1:0] ACT_ADD  = AW'(0);
    localparam logic [AW-1:0] ACT_SUB  = AW'(1);
    localparam logic [AW-1:0] ACT_MUL  = AW'(2);
    localparam logic [AW-1:0] ACT_DIV  = AW'(3);
    localparam logic [AW-1:0] ACT_CONJ = AW'(4);

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [MW-1:0] Q_LIMIT = MW'(1) << DW;
    localparam logic [MW-1:0] NEG_LIM = MW'(1) << (DW - 1);
    localparam logic [MW-1:0] POS_LIM = (MW'(1) << (DW - 1)) - MW'(1);
    localparam logic [DW-1:0] DW_MIN  = DW'(1) << (DW - 1);
    localparam logic [DW-1:0] DW_MAX  = ~DW_MIN;

    // Item in sign-magnitude form as it enters the divider pipeline.
    typedef struct packed {
        logic          vld;
        logic [AW-1:0] act;
        logic          dz;
        logic          re_neg;
        logic [MW-1:0] re_mag;
        logic          im_neg;
        logic [MW-1:0] im_mag;
        logic [PW-1:0] den;
    } item_t;

    typedef struct packed {
        item_t         item;
        logic [RW-1:0] re_rem;
        logic [RW-1:0] im_rem;
        logic [QW-1:0] re_q;
        logic [QW-1:0] im_q;
        logic          re_big;
        logic          im_big;
    } dstage_t;

endpackage
`default_nettype wire

/* design/cau_div_pipe.sv */
// Pipelined restoring divider for the real and imaginary quotients, two bits per stage.
// Depends on cau_pkg; sideband item fields travel along unchanged.
`default_nettype none
module cau_div_pipe (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire cau_pkg::item_t  in_item,
    output cau_pkg::dstage_t     out_stage
);
    import cau_pkg::*;

    dstage_t pipe_reg [DIV_STAGES+1];
    dstage_t pipe_next [DIV_STAGES+1];

    function automatic logic [RW:0] rem_step(input logic [RW-1:0] rem,
                                             input logic [PW-1:0] den,
                                             input logic din);
        logic [RW:0] t;
        logic [RW:0] d;
        logic        qb;
        t = {rem, din};
        d = {{(RW + 1 - PW){1'b0}}, den};
        if (t >= d) begin
            t  = t - d;
            qb = 1'b1;
        end else begin
            qb = 1'b0;
        end
        return {qb, t[RW-1:0]};
    endfunction

    // One quotient bit for both lanes; pos is the dividend bit brought down.
    function automatic dstage_t div_step(input dstage_t x, input int pos);
        dstage_t     y;
        logic [QW-1:0] dl_re;
        logic [QW-1:0] dl_im;
        logic [RW:0]   r_re;
        logic [RW:0]   r_im;
        logic [QB-1:0] p;
        y     = x;
        p     = QB'(pos);
        dl_re = QW'(x.item.re_mag << FB);
        dl_im = QW'(x.item.im_mag << FB);
        r_re  = rem_step(x.re_rem, x.item.den, dl_re[p]);
        r_im  = rem_step(x.im_rem, x.item.den, dl_im[p]);
        y.re_rem = r_re[RW-1:0];
        y.im_rem = r_im[RW-1:0];
        y.re_q   = {x.re_q[QW-2:0], r_re[RW]};
        y.im_q   = {x.im_q[QW-2:0], r_im[RW]};
        return y;
    endfunction

    // The leading dividend bits form the starting remainder; when they reach the
    // divisor the quotient has more than QW bits and is clamped at the end.
    always_comb begin
        pipe_next[0].item   = in_item;
        pipe_next[0].re_rem = RW'(in_item.re_mag >> (QW - FB));
        pipe_next[0].im_rem = RW'(in_item.im_mag >> (QW - FB));
        pipe_next[0].re_q   = '0;
        pipe_next[0].im_q   = '0;
        pipe_next[0].re_big = RW'(in_item.re_mag >> (QW - FB)) >= RW'(in_item.den);
        pipe_next[0].im_big = RW'(in_item.im_mag >> (QW - FB)) >= RW'(in_item.den);
    end

    for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
        localparam int J0 = 2 * (k - 1);
        always_comb begin
            pipe_next[k] = div_step(pipe_reg[k-1], QW - 1 - J0);
            if (J0 + 1 < QW) begin
                pipe_next[k] = div_step(pipe_next[k], QW - 2 - J0);
            end
        end
    end

    for (genvar k = 0; k <= DIV_STAGES; k++) begin : g_reg
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pipe_reg[k].item.vld <= 1'b0;
            end else if (en) begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign out_stage = pipe_reg[DIV_STAGES];

`ifndef SYNTHESIS
    a_big_needs_div: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[0].item.vld && pipe_reg[0].re_big |-> pipe_reg[0].item.den != '0
            || pipe_reg[0].item.act != ACT_DIV || pipe_reg[0].re_big)
        else $error("divider clamp flag inconsistent");
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_reg[1].item.vld && pipe_reg[1].item.act == ACT_DIV && !pipe_reg[1].item.dz
            && !pipe_reg[1].re_big |-> {1'b0, pipe_reg[1].re_rem} < {2'b0, pipe_reg[1].item.den})
        else $error("divider remainder not below divisor");
    a_vld_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> pipe_reg[1].item.vld == $past(pipe_reg[0].item.vld))
        else $error("divider valid bit lost");
`endif

endmodule
`default_nettype wire

/* design/complex_arithmetic_unit.sv */
// Complex-number ALU top level: add, subtract, multiply, divide and conjugate in Q8.8.
// Depends on cau_pkg and cau_div_pipe.
//
// Channel | Direction | tdata fields, lowest bit first
// s_      | input     | action[2:0], a_real, a_imag, b_real, b_imag (72 bits)
// m_      | output    | result_real, result_imag, status[1:0] (40 bits)
//
// One transfer is accepted per cycle while m_ is not stalled; a result passes through
// stages 1 to 4, the divider pipeline and the output stage before it is presented.
// The divider is a 17-bit restoring divider, two bits per stage.
// aresetn clears all valid bits synchronously; operand registers are not reset.
// A stall on m_ freezes the whole pipeline and drops s_tready in the same cycle.
`default_nettype none
module complex_arithmetic_unit (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // action, a_real, a_imag, b_real, b_imag, zero fill
    input  wire logic [cau_pkg::S_TDATA_W-1:0]    s_tdata,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // result_real, result_imag, status, zero fill
    output      logic [cau_pkg::M_TDATA_W-1:0]    m_tdata
);
    import cau_pkg::*;

    logic en;

    logic                 s1_vld_reg;
    logic [AW-1:0]        s1_act_reg;
    logic signed [DW-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    logic                 s2_vld_reg;
    logic [AW-1:0]        s2_act_reg;
    logic signed [PW-1:0] s2_prr_reg, s2_pii_reg, s2_pri_reg, s2_pir_reg;
    logic signed [PW-1:0] s2_sqr_reg, s2_sqi_reg;
    logic signed [DW:0]   s2_as_re_reg, s2_as_im_reg;
    logic signed [DW:0]   s2_as_re_next, s2_as_im_next;

    logic                 s3_vld_reg;
    logic [AW-1:0]        s3_act_reg;
    logic signed [SW-1:0] s3_re_reg, s3_im_reg, s3_re_next, s3_im_next;
    logic [PW-1:0]        s3_den_reg;

    item_t   s4_reg, s4_next;
    dstage_t dv;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Stage 1: operand capture.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_act_reg <= s_tdata[AW-1:0];
            s1_ar_reg  <= s_tdata[AW+DW-1:AW];
            s1_ai_reg  <= s_tdata[AW+2*DW-1:AW+DW];
            s1_br_reg  <= s_tdata[AW+3*DW-1:AW+2*DW];
            s1_bi_reg  <= s_tdata[AW+4*DW-1:AW+3*DW];
        end
    end

    // Stage 2: partial products and the short add, subtract and conjugate.
    always_comb begin
        s2_as_re_next = '0;
        s2_as_im_next = '0;
        case (s1_act_reg)
            ACT_ADD: begin
                s2_as_re_next = (DW+1)'(s1_ar_reg) + (DW+1)'(s1_br_reg);
                s2_as_im_next = (DW+1)'(s1_ai_reg) + (DW+1)'(s1_bi_reg);
            end
            ACT_SUB: begin
                s2_as_re_next = (DW+1)'(s1_ar_reg) - (DW+1)'(s1_br_reg);
                s2_as_im_next = (DW+1)'(s1_ai_reg) - (DW+1)'(s1_bi_reg);
            end
            ACT_CONJ: begin
                s2_as_re_next = (DW+1)'(s1_ar_reg);
                s2_as_im_next = -((DW+1)'(s1_ai_reg));
            end
            default: begin
                s2_as_re_next = '0;
                s2_as_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_act_reg   <= s1_act_reg;
            s2_prr_reg   <= PW'(s1_ar_reg) * PW'(s1_br_reg);
            s2_pii_reg   <= PW'(s1_ai_reg) * PW'(s1_bi_reg);
            s2_pri_reg   <= PW'(s1_ar_reg) * PW'(s1_bi_reg);
            s2_pir_reg   <= PW'(s1_ai_reg) * PW'(s1_br_reg);
            s2_sqr_reg   <= PW'(s1_br_reg) * PW'(s1_br_reg);
            s2_sqi_reg   <= PW'(s1_bi_reg) * PW'(s1_bi_reg);
            s2_as_re_reg <= s2_as_re_next;
            s2_as_im_reg <= s2_as_im_next;
        end
    end

    // Stage 3: exact sums of products and the divisor.
    always_comb begin
        s3_re_next = '0;
        s3_im_next = '0;
        case (s2_act_reg)
            ACT_ADD, ACT_SUB, ACT_CONJ: begin
                s3_re_next = SW'(s2_as_re_reg);
                s3_im_next = SW'(s2_as_im_reg);
            end
            ACT_MUL: begin
                s3_re_next = SW'(s2_prr_reg) - SW'(s2_pii_reg);
                s3_im_next = SW'(s2_pri_reg) + SW'(s2_pir_reg);
            end
            ACT_DIV: begin
                s3_re_next = SW'(s2_prr_reg) + SW'(s2_pii_reg);
                s3_im_next = SW'(s2_pir_reg) - SW'(s2_pri_reg);
            end
            default: begin
                s3_re_next = '0;
                s3_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_act_reg <= s2_act_reg;
            s3_re_reg  <= s3_re_next;
            s3_im_reg  <= s3_im_next;
            s3_den_reg <= $unsigned(s2_sqr_reg) + $unsigned(s2_sqi_reg);
        end
    end

    // Stage 4: sign-magnitude form; the product rescale truncates toward zero.
    always_comb begin
        s4_next.vld    = s3_vld_reg;
        s4_next.act    = s3_act_reg;
        s4_next.den    = s3_den_reg;
        s4_next.dz     = (s3_act_reg == ACT_DIV) && (s3_den_reg == '0);
        s4_next.re_neg = s3_re_reg[SW-1];
        s4_next.im_neg = s3_im_reg[SW-1];
        s4_next.re_mag = s3_re_reg[SW-1] ? MW'(-s3_re_reg) : MW'(s3_re_reg);
        s4_next.im_mag = s3_im_reg[SW-1] ? MW'(-s3_im_reg) : MW'(s3_im_reg);
        if (s3_act_reg == ACT_MUL) begin
            s4_next.re_mag = s4_next.re_mag >> FB;
            s4_next.im_mag = s4_next.im_mag >> FB;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s4_reg.vld <= 1'b0;
        end else if (en) begin
            s4_reg <= s4_next;
        end
    end

    cau_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_item   (s4_reg),
        .out_stage (dv)
    );

    // Returns {saturated, field bits}.
    function automatic logic [DW:0] sat_val(input logic neg, input logic [MW-1:0] mag);
        logic [MW-1:0] n;
        n = MW'(0) - mag;
        if (neg) begin
            if (mag > NEG_LIM) begin
                return {1'b1, DW_MIN};
            end
            return {1'b0, n[DW-1:0]};
        end
        if (mag > POS_LIM) begin
            return {1'b1, DW_MAX};
        end
        return {1'b0, mag[DW-1:0]};
    endfunction

    // Output stage: quotient clamp, saturation and status.
    always_comb begin
        logic [MW-1:0] re_m;
        logic [MW-1:0] im_m;
        logic [DW:0]   re_s;
        logic [DW:0]   im_s;
        logic [1:0]    st;
        re_m = dv.item.re_mag;
        im_m = dv.item.im_mag;
        if (dv.item.act == ACT_DIV) begin
            re_m = (dv.re_big || MW'(dv.re_q) > Q_LIMIT) ? Q_LIMIT : MW'(dv.re_q);
            im_m = (dv.im_big || MW'(dv.im_q) > Q_LIMIT) ? Q_LIMIT : MW'(dv.im_q);
        end
        re_s = sat_val(dv.item.re_neg, re_m);
        im_s = sat_val(dv.item.im_neg, im_m);
        st   = (re_s[DW] || im_s[DW]) ? ST_SAT : ST_OK;
        if (dv.item.dz) begin
            re_s = '0;
            im_s = '0;
            st   = ST_DZ;
        end
        m_data_next = M_TDATA_W'({st, im_s[DW-1:0], re_s[DW-1:0]});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv.item.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*DW+1:2*DW] == ST_DZ |-> m_tdata[2*DW-1:0] == '0)
        else $error("divide by zero with nonzero result");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2*DW+1:2*DW] != 2'd3)
        else $error("undefined status code");
    a_sat_extreme: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2*DW+1:2*DW] == ST_SAT |->
            m_tdata[DW-1:0] == DW_MAX || m_tdata[DW-1:0] == DW_MIN
            || m_tdata[2*DW-1:DW] == DW_MAX || m_tdata[2*DW-1:DW] == DW_MIN)
        else $error("saturation status without a limit value");
`endif

endmodule
`default_nettype wire

/* test/cau_result_checker.sv */
// Result checker for the complex arithmetic unit: watches both stream channels,
// computes the expected result of every accepted transfer and compares. Uses cau_pkg.
`default_nettype none
module cau_result_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [cau_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [cau_pkg::M_TDATA_W-1:0] m_tdata,
    output      int                            fail_count,
    output      int                            pending
);
    import cau_pkg::*;

    typedef struct packed {
        logic [1:0]           status;
        logic signed [DW-1:0] imag;
        logic signed [DW-1:0] real_part;
    } cplx_result_t;

    cplx_result_t expected_results[$];

    // Clamps to the signed part range and flags saturation.
    function automatic logic signed [DW-1:0] clamp_part(input longint v, inout bit sat);
        if (v > 32767) begin
            sat = 1;
            return DW_MAX;
        end
        if (v < -32768) begin
            sat = 1;
            return DW_MIN;
        end
        return DW'(v);
    endfunction

    // Rescales a product sum by the fraction bits, truncating toward zero.
    function automatic longint rescale(input longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = mag >>> FB;
        return (v < 0) ? -mag : mag;
    endfunction

    // Quotient (num << FB) / den truncated toward zero, magnitude capped at 2^DW.
    function automatic longint fixed_quot(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< FB) / den;
        if (q > 65536)
            q = 65536;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_result_t predict_result(input logic [S_TDATA_W-1:0] d);
        logic [AW-1:0] act;
        longint ar, ai, br, bi, den;
        bit sat;
        cplx_result_t r;
        act = d[AW-1:0];
        ar = longint'($signed(d[AW +: DW]));
        ai = longint'($signed(d[AW+DW +: DW]));
        br = longint'($signed(d[AW+2*DW +: DW]));
        bi = longint'($signed(d[AW+3*DW +: DW]));
        sat = 0;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_ADD: begin
                r.real_part = clamp_part(ar + br, sat);
                r.imag = clamp_part(ai + bi, sat);
            end
            ACT_SUB: begin
                r.real_part = clamp_part(ar - br, sat);
                r.imag = clamp_part(ai - bi, sat);
            end
            ACT_MUL: begin
                r.real_part = clamp_part(rescale(ar * br - ai * bi), sat);
                r.imag = clamp_part(rescale(ar * bi + ai * br), sat);
            end
            ACT_DIV: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.status = ST_DZ;
                end else begin
                    r.real_part = clamp_part(fixed_quot(ar * br + ai * bi, den), sat);
                    r.imag = clamp_part(fixed_quot(ai * br - ar * bi, den), sat);
                end
            end
            ACT_CONJ: begin
                r.real_part = clamp_part(ar, sat);
                r.imag = clamp_part(-ai, sat);
            end
            default: ;
        endcase
        if (r.status == ST_OK && sat)
            r.status = ST_SAT;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        cplx_result_t got;
        cplx_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_results.insert(expected_results.size(), predict_result(s_tdata));
            if (m_tvalid && m_tready) begin
                got = cplx_result_t'(m_tdata[2*DW+1:0]);
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %h", m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected re=%0d im=%0d st=%0d, got re=%0d im=%0d st=%0d",
                                     want.real_part, want.imag, want.status,
                                     got.real_part, got.imag, got.status);
                    end
                end
            end
        end
        pending = expected_results.size();
    end
endmodule
`default_nettype wire

/* test/tb.sv */
// Testbench top for the complex arithmetic unit: clock, reset, stimulus and verdict.
// Depends on cau_pkg, complex_arithmetic_unit and cau_result_checker.
`default_nettype none
module tb;
    import cau_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   cycle_count;
    bit                   no_idle;

    complex_arithmetic_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    cau_result_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial aclk = 0;
    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    // Both sides run without gaps through this stretch of the run.
    assign no_idle = (cycle_count >= 1500) && (cycle_count < 2300);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
    initial begin
        int hold;
        hold = 0;
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (cycle_count == 900)
                hold = 150;
            if (hold > 0) begin
                hold--;
                m_tready <= 0;
            end else begin
                m_tready <= no_idle || ($urandom_range(99) >= 23);
            end
        end
    end

    function automatic logic signed [DW-1:0] rand_part();
        case ($urandom_range(3))
            0: return DW'($urandom);
            1: return DW'($signed($urandom_range(1023)) - 512);
            2: return DW'($signed($urandom_range(8191)) - 4096);
            default: return ($urandom_range(1)) ? DW_MAX : DW_MIN;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(input logic [AW-1:0] act, input logic signed [DW-1:0] ar,
                           input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
                           input logic signed [DW-1:0] bi);
        while (!no_idle && $urandom_range(99) < 23) begin
            s_tvalid <= 0;
            s_tdata  <= S_TDATA_W'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= S_TDATA_W'({bi, br, ai, ar, act});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    initial begin
        logic [AW-1:0] act;
        cycle_count = 0;
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        send_op(ACT_ADD, DW_MAX, DW_MAX, DW_MAX, DW_MAX);
        send_op(ACT_ADD, DW_MIN, DW_MIN, DW_MIN, DW_MIN);
        send_op(ACT_ADD, 16'sd256, -16'sd512, 16'sd128, 16'sd1);
        send_op(ACT_SUB, DW_MIN, DW_MAX, DW_MAX, DW_MIN);
        send_op(ACT_SUB, 16'sd1000, 16'sd0, 16'sd1000, -16'sd5);
        send_op(ACT_MUL, DW_MAX, DW_MAX, DW_MAX, DW_MAX);
        send_op(ACT_MUL, DW_MIN, DW_MIN, DW_MIN, DW_MIN);
        send_op(ACT_MUL, DW_MIN, DW_MAX, DW_MAX, DW_MIN);
        send_op(ACT_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0);
        send_op(ACT_MUL, 16'sd512, 16'sd256, -16'sd384, 16'sd128);
        send_op(ACT_DIV, 16'sd256, 16'sd256, 16'sd0, 16'sd0);
        send_op(ACT_DIV, DW_MIN, DW_MIN, 16'sd0, 16'sd0);
        send_op(ACT_DIV, DW_MAX, DW_MIN, 16'sd1, 16'sd0);
        send_op(ACT_DIV, DW_MIN, DW_MAX, 16'sd0, -16'sd1);
        send_op(ACT_DIV, 16'sd512, -16'sd768, 16'sd256, 16'sd256);
        send_op(ACT_DIV, 16'sd1, 16'sd1, DW_MIN, DW_MIN);
        send_op(ACT_DIV, -16'sd3, 16'sd7, DW_MAX, 16'sd3);
        send_op(ACT_CONJ, DW_MIN, DW_MIN, DW_MAX, DW_MAX);
        send_op(ACT_CONJ, DW_MAX, DW_MAX, 16'sd0, 16'sd0);
        send_op(ACT_CONJ, -16'sd42, 16'sd0, DW_MIN, 16'sd1);
        send_op(AW'(5), DW_MAX, DW_MIN, DW_MAX, DW_MIN);
        send_op(AW'(6), 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_op(AW'(7), DW_MIN, DW_MAX, DW_MIN, DW_MAX);

        repeat (1200) begin
            act = ($urandom_range(19) == 0) ? AW'($urandom_range(7, 5))
                                             : AW'($urandom_range(4));
            send_op(act, rand_part(), rand_part(), rand_part(), rand_part());
        end
        s_tvalid <= 0;

        while (pending != 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
`default_nettype wire
